// ----- src/aema_pkg.sv -----
// Shared types, constants and helpers for the asymmetric EMA channel bank.
`timescale 1ns / 1ps
`default_nettype none

package aema_pkg;

   localparam int CMD_W   = 2;
   localparam int CH_W    = 6;
   localparam int SMP_W   = 8;
   localparam int VAL_W   = 24;
   localparam int FAC_W   = 17;
   localparam int FRAC_W  = 16;
   localparam int APB_AW  = 3;
   localparam int APB_DW  = 32;

   localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd0;
   localparam logic [CMD_W-1:0] CMD_READ   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

   localparam logic REG_RISE = 1'b0;
   localparam logic REG_FALL = 1'b1;

   localparam logic [FAC_W-1:0]  ONE_Q16  = 17'h10000;
   localparam logic [VAL_W-1:0]  HALF_Q16 = 24'h008000;
   localparam logic [VAL_W-1:0]  MAX_VAL  = 24'hFF0000;

   typedef struct packed {
      logic [FAC_W-1:0] rise;
      logic [FAC_W-1:0] fall;
   } cfg_type;

   typedef struct packed {
      logic             rd_en;
      logic [CH_W-1:0]  rd_ch;
      logic             wr_en;
      logic [CH_W-1:0]  wr_ch;
      logic [VAL_W-1:0] wr_data;
      logic             clear;
   } store_cmd_type;

   // Q8.16 to byte, round half up.
   function automatic logic [SMP_W-1:0] round_byte(input logic [VAL_W-1:0] q);
      logic [VAL_W:0] sum;
      sum = {1'b0, q} + {1'b0, HALF_Q16};
      return sum[FRAC_W +: SMP_W];
   endfunction

endpackage

`default_nettype wire

// ----- src/aema_if.sv -----
// Valid/ready channel interfaces for request and response items.
`timescale 1ns / 1ps
`default_nettype none

interface aema_req_if;
   logic                         valid;
   logic                         ready;
   logic [aema_pkg::CMD_W-1:0]   command;
   logic [aema_pkg::CH_W-1:0]    channel;
   logic [aema_pkg::SMP_W-1:0]   sample;
   logic                         frame_last;

   modport source (output valid, command, channel, sample, frame_last, input ready);
   modport sink   (input valid, command, channel, sample, frame_last, output ready);
endinterface

interface aema_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [aema_pkg::CH_W-1:0]    out_channel;
   logic [aema_pkg::SMP_W-1:0]   smoothed_value;
   logic                         primed;

   modport source (output valid, out_channel, smoothed_value, primed, input ready);
   modport sink   (input valid, out_channel, smoothed_value, primed, output ready);
endinterface

`default_nettype wire

// ----- src/aema_csr.sv -----
// APB-style register block holding the rise and fall factors.
`timescale 1ns / 1ps
`default_nettype none

module aema_csr (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        csr_psel,
   input  wire logic                        csr_penable,
   input  wire logic                        csr_pwrite,
   input  wire logic [aema_pkg::APB_AW-1:0] csr_paddr,
   input  wire logic [aema_pkg::APB_DW-1:0] csr_pwdata,
   output logic      [aema_pkg::APB_DW-1:0] csr_prdata,
   output logic                             csr_pready,
   output aema_pkg::cfg_type                cfg
);

   logic [aema_pkg::FAC_W-1:0] rise_ff;
   logic [aema_pkg::FAC_W-1:0] fall_ff;
   logic [aema_pkg::FAC_W-1:0] wdata_in;
   logic                       wr_en;
   logic                       reg_sel;

   assign csr_pready = 1'b1;
   assign reg_sel    = csr_paddr[2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // factors above one saturate
   always_comb begin
      wdata_in = csr_pwdata[aema_pkg::FAC_W-1:0];
      if (wdata_in > aema_pkg::ONE_Q16) begin
         wdata_in = aema_pkg::ONE_Q16;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rise_ff <= aema_pkg::ONE_Q16;
         fall_ff <= aema_pkg::ONE_Q16;
      end else if (wr_en) begin
         case (reg_sel)
            aema_pkg::REG_RISE: rise_ff <= wdata_in;
            aema_pkg::REG_FALL: fall_ff <= wdata_in;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         aema_pkg::REG_RISE: csr_prdata = aema_pkg::APB_DW'(rise_ff);
         aema_pkg::REG_FALL: csr_prdata = aema_pkg::APB_DW'(fall_ff);
         default:            csr_prdata = '0;
      endcase
   end

   assign cfg.rise = rise_ff;
   assign cfg.fall = fall_ff;

endmodule

`default_nettype wire

// ----- src/aema_store.sv -----
// Channel value memory with per-entry valid flags and write-back forwarding.
`timescale 1ns / 1ps
`default_nettype none

module aema_store #(
   parameter int CHANNELS = 64
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire aema_pkg::store_cmd_type      cmd,
   output logic [aema_pkg::VAL_W-1:0]        rd_value
);

   localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   logic [aema_pkg::VAL_W-1:0] mem [CHANNELS];
   logic [aema_pkg::VAL_W-1:0] rd_data_ff;
   logic [aema_pkg::CH_W-1:0]  rd_ch_ff;
   logic [CHANNELS-1:0]        valid_ff;
   logic                       wb_valid_ff;
   logic [aema_pkg::CH_W-1:0]  wb_ch_ff;
   logic [aema_pkg::VAL_W-1:0] wb_data_ff;
   logic [AW-1:0]              rd_addr;
   logic [AW-1:0]              wr_addr;
   logic [AW-1:0]              rd_addr_ff;

   assign rd_addr    = AW'(cmd.rd_ch);
   assign wr_addr    = AW'(cmd.wr_ch);
   assign rd_addr_ff = AW'(rd_ch_ff);

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[wr_addr] <= cmd.wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem[rd_addr];
         rd_ch_ff   <= cmd.rd_ch;
      end
      if (cmd.wr_en) begin
         wb_ch_ff   <= cmd.wr_ch;
         wb_data_ff <= cmd.wr_data;
      end
   end

   // clear drops every entry back to zero at once
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         wb_valid_ff <= 1'b0;
      end else if (cmd.clear) begin
         valid_ff    <= '0;
         wb_valid_ff <= 1'b0;
      end else if (cmd.wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
         wb_valid_ff       <= 1'b1;
      end
   end

   // a write landing on the read edge is missed by the array: take it from wb
   always_comb begin
      if (wb_valid_ff && (wb_ch_ff == rd_ch_ff)) begin
         rd_value = wb_data_ff;
      end else if (valid_ff[rd_addr_ff]) begin
         rd_value = rd_data_ff;
      end else begin
         rd_value = '0;
      end
   end

endmodule

`default_nettype wire

// ----- src/aema_blend.sv -----
// Two-stage blend: registered products, then round and sum.
`timescale 1ns / 1ps
`default_nettype none

module aema_blend (
   input  wire logic                         clock,
   input  wire logic                         en,
   input  wire logic [aema_pkg::VAL_W-1:0]   prev,
   input  wire logic [aema_pkg::SMP_W-1:0]   sample,
   input  wire logic [aema_pkg::FAC_W-1:0]   factor,
   output logic      [aema_pkg::VAL_W-1:0]   next_value
);

   localparam int PP_W = aema_pkg::VAL_W + aema_pkg::FAC_W;
   localparam int PS_W = aema_pkg::SMP_W + aema_pkg::FAC_W;

   logic [aema_pkg::FAC_W-1:0] inv_factor;
   logic [PP_W-1:0]            prod_p_in;
   logic [PS_W-1:0]            prod_s_in;
   logic [PP_W-1:0]            prod_p_ff;
   logic [PS_W-1:0]            prod_s_ff;
   logic [PP_W-1:0]            rounded;

   assign inv_factor = aema_pkg::ONE_Q16 - factor;
   assign prod_p_in  = PP_W'(prev) * PP_W'(inv_factor);
   assign prod_s_in  = PS_W'(sample) * PS_W'(factor);

   always_ff @(posedge clock) begin
      if (en) begin
         prod_p_ff <= prod_p_in;
         prod_s_ff <= prod_s_in;
      end
   end

   // target term is sample*factor<<16, so it adds after the shift exactly
   assign rounded    = prod_p_ff + PP_W'(aema_pkg::HALF_Q16);
   assign next_value = aema_pkg::VAL_W'(rounded >> aema_pkg::FRAC_W)
                     + aema_pkg::VAL_W'(prod_s_ff);

endmodule

`default_nettype wire

// ----- src/asymmetric_ema_channel_bank_top.sv -----
// Top level of the asymmetric EMA channel bank.
//
// Usage: request items arrive on req (command, channel, sample, frame_last),
// one response item per request leaves on rsp in request order. A sample
// item moves its channel toward the sample with the rise or fall factor,
// a read item reports the channel, a clear item zeroes every channel and
// unprimes the bank. Factors are written through the csr APB port.
// Pipeline: accept + array read, factor select + multiply, sum + write-back
// into the response register. Throughput: one item per cycle while rsp is
// taken. A sample on channel c followed right away by any non-clear item on c
// holds that item back while the sample sits in stage 1; the multiply-add loop
// on one channel value forces this. Other orders run at full rate.
// Reset: all channels read as zero at once (per-entry valid flags, no
// sweep), the bank is unprimed and both factors are one.
// Stall: while rsp is held, the stages keep filling until all three hold an
// item, then req.ready drops; nothing is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none

module asymmetric_ema_channel_bank_top #(
   parameter int CHANNELS = 64
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   aema_req_if.sink                         req,
   aema_rsp_if.source                       rsp,
   input  wire logic                        csr_psel,
   input  wire logic                        csr_penable,
   input  wire logic                        csr_pwrite,
   input  wire logic [aema_pkg::APB_AW-1:0] csr_paddr,
   input  wire logic [aema_pkg::APB_DW-1:0] csr_pwdata,
   output logic      [aema_pkg::APB_DW-1:0] csr_prdata,
   output logic                             csr_pready
);

   aema_pkg::cfg_type       cfg;
   aema_pkg::store_cmd_type store_cmd;
   logic [aema_pkg::VAL_W-1:0] store_value;

   // stage enables, back to front
   logic en_out, en2, en1, accept, hazard, adv1, adv2;

   // stage 1: item whose stored value is being read
   logic                        s1_v_ff;
   logic [aema_pkg::CMD_W-1:0]  s1_cmd_ff;
   logic [aema_pkg::CH_W-1:0]   s1_ch_ff;
   logic [aema_pkg::SMP_W-1:0]  s1_smp_ff;
   logic                        s1_last_ff;
   logic                        s1_sample, s1_clear, s1_inr, s1_wr;
   logic [aema_pkg::VAL_W-1:0]  s1_prev;
   logic [aema_pkg::VAL_W-1:0]  s1_target;
   logic [aema_pkg::FAC_W-1:0]  s1_factor;
   logic                        primed_ff;
   logic                        primed_in;

   // stage 2: products registered, write-back pending
   logic                        s2_v_ff;
   logic                        s2_clear_ff;
   logic                        s2_wr_ff;
   logic                        s2_inr_ff;
   logic [aema_pkg::CH_W-1:0]   s2_ch_ff;
   logic                        s2_primed_ff;
   logic [aema_pkg::VAL_W-1:0]  s2_prev_ff;
   logic [aema_pkg::VAL_W-1:0]  s2_next;
   logic [aema_pkg::SMP_W-1:0]  s2_value;

   // response register
   logic                        rsp_v_ff;
   logic [aema_pkg::CH_W-1:0]   rsp_ch_ff;
   logic [aema_pkg::SMP_W-1:0]  rsp_value_ff;
   logic                        rsp_primed_ff;

   aema_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   assign en_out = !rsp_v_ff || rsp.ready;
   assign en2    = !s2_v_ff || en_out;
   assign en1    = !s1_v_ff || en2;
   assign adv1   = s1_v_ff && en2;
   assign adv2   = s2_v_ff && en_out;

   // Interlock: a non-clear item may not read a channel whose sample update
   // is still ahead of it in stage 1, or parked unwritten in stage 2.
   always_comb begin
      hazard = 1'b0;
      if (req.command != aema_pkg::CMD_CLEAR) begin
         if (s1_v_ff && s1_wr && (s1_ch_ff == req.channel)) begin
            hazard = 1'b1;
         end
         if (s2_v_ff && s2_wr_ff && (s2_ch_ff == req.channel) && !en_out) begin
            hazard = 1'b1;
         end
      end
   end

   assign req.ready = en1 && !hazard;
   assign accept    = req.valid && req.ready;

   // ---------------- stage 1 ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else if (en1) begin
         s1_v_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_cmd_ff  <= req.command;
         s1_ch_ff   <= req.channel;
         s1_smp_ff  <= req.sample;
         s1_last_ff <= req.frame_last;
      end
   end

   assign s1_sample = (s1_cmd_ff == aema_pkg::CMD_SAMPLE);
   assign s1_clear  = (s1_cmd_ff == aema_pkg::CMD_CLEAR);
   assign s1_inr    = (int'(s1_ch_ff) < CHANNELS);
   assign s1_wr     = s1_sample && s1_inr;
   assign s1_target = {s1_smp_ff, aema_pkg::FRAC_W'(0)};

   // a clear still in stage 2 lands on the same edge this item moves on
   assign s1_prev = (s2_v_ff && s2_clear_ff) ? '0 : store_value;

   // unprimed: factor one stores the raw sample
   always_comb begin
      if (!primed_ff) begin
         s1_factor = aema_pkg::ONE_Q16;
      end else if (s1_target > s1_prev) begin
         s1_factor = cfg.rise;
      end else begin
         s1_factor = cfg.fall;
      end
   end

   always_comb begin
      primed_in = primed_ff;
      if (s1_clear) begin
         primed_in = 1'b0;
      end else if (s1_sample && s1_last_ff) begin
         primed_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         primed_ff <= 1'b0;
      end else if (adv1) begin
         primed_ff <= primed_in;
      end
   end

   // ---------------- stage 2 ----------------
   aema_blend u_blend (
      .clock      (clock),
      .en         (en2),
      .prev       (s1_prev),
      .sample     (s1_smp_ff),
      .factor     (s1_factor),
      .next_value (s2_next)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
      end else if (en2) begin
         s2_v_ff <= s1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         s2_clear_ff  <= s1_clear;
         s2_wr_ff     <= s1_wr;
         s2_inr_ff    <= s1_inr;
         s2_ch_ff     <= s1_ch_ff;
         s2_primed_ff <= primed_in;
         s2_prev_ff   <= s1_prev;
      end
   end

   always_comb begin
      if (s2_clear_ff || !s2_inr_ff) begin
         s2_value = '0;
      end else if (s2_wr_ff) begin
         s2_value = aema_pkg::round_byte(s2_next);
      end else begin
         s2_value = aema_pkg::round_byte(s2_prev_ff);
      end
   end

   // ---------------- store ----------------
   always_comb begin
      store_cmd.rd_en   = accept;
      store_cmd.rd_ch   = req.channel;
      store_cmd.wr_en   = adv2 && s2_wr_ff;
      store_cmd.wr_ch   = s2_ch_ff;
      store_cmd.wr_data = s2_next;
      store_cmd.clear   = adv2 && s2_clear_ff;
   end

   aema_store #(
      .CHANNELS (CHANNELS)
   ) u_store (
      .clock    (clock),
      .reset    (reset),
      .cmd      (store_cmd),
      .rd_value (store_value)
   );

   // ---------------- response ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_v_ff <= 1'b0;
      end else if (en_out) begin
         rsp_v_ff <= s2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en_out) begin
         rsp_ch_ff     <= s2_clear_ff ? '0 : s2_ch_ff;
         rsp_value_ff  <= s2_value;
         rsp_primed_ff <= s2_primed_ff;
      end
   end

   assign rsp.valid          = rsp_v_ff;
   assign rsp.out_channel    = rsp_ch_ff;
   assign rsp.smoothed_value = rsp_value_ff;
   assign rsp.primed         = rsp_primed_ff;

   // ---------------- checks ----------------
   // interlock: stage 1 never reads past an unwritten update of its channel
   a_no_stale_read: assert property (@(posedge clock) disable iff (reset)
      (s1_v_ff && !s1_clear && s2_v_ff && s2_wr_ff) |-> (s1_ch_ff != s2_ch_ff))
      else $error("stage 1 overlaps pending update on same channel");

   // blended value stays between previous and target, so within Q8.16 range
   a_value_bound: assert property (@(posedge clock) disable iff (reset)
      store_cmd.wr_en |-> (store_cmd.wr_data <= aema_pkg::MAX_VAL))
      else $error("write-back value out of range");

   // a held response freezes write-back
   a_stall_no_write: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.ready) |-> !(store_cmd.wr_en || store_cmd.clear))
      else $error("store updated while response stalled");

endmodule

`default_nettype wire
